// ----- rtl/bta_pkg.sv -----
// Shared constants, codes and types of the boundary-tag heap allocator.
package bta_pkg;

	localparam int unsigned BTA_ARENA_BYTES = 16384;
	localparam int unsigned HDR_BYTES       = 12;
	localparam int unsigned MIN_ARENA       = 64;

	localparam int unsigned ADDR_W  = 14;
	localparam int unsigned ACT_W   = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CFG_W   = 15;
	localparam int unsigned TDATA_W = 32;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic busy;
		logic size;
		logic prev;
	} bta_we_t;

	typedef struct packed {
		logic [ADDR_W-1:0] old_address;
		logic              moved;
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] result_address;
	} bta_res_t;

endpackage

// ----- rtl/bta_alu.sv -----
// Shared adder of the allocator: a +/- b +/- header size.
module bta_alu import bta_pkg::*; #(
	parameter int unsigned OW = 17
) (
	input  logic [OW-1:0] a,
	input  logic [OW-1:0] b,
	input  logic          hdr,
	input  logic          sub,
	output logic [OW-1:0] y
);

	logic [OW-1:0] k;

	assign k = hdr ? OW'(HDR_BYTES) : '0;
	assign y = sub ? (a - b - k) : (a + b + k);

endmodule

// ----- rtl/bta_hdr_ram.sv -----
// Header store: busy, size and previous size per 4-byte word, one write and one read port.
module bta_hdr_ram import bta_pkg::*; #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned DW    = 17
) (
	input  logic                     clk,
	input  bta_we_t                  we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic                     wbusy,
	input  logic [DW-1:0]            wsize,
	input  logic [DW-1:0]            wprev,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     rbusy,
	output logic [DW-1:0]            rsize,
	output logic [DW-1:0]            rprev
);

	logic          busy_m [DEPTH];
	logic [DW-1:0] size_m [DEPTH];
	logic [DW-1:0] prev_m [DEPTH];

	always_ff @(posedge clk) begin
		if (we.busy) begin
			busy_m[waddr] <= wbusy;
		end
		if (we.size) begin
			size_m[waddr] <= wsize;
		end
		if (we.prev) begin
			prev_m[waddr] <= wprev;
		end
		rbusy <= busy_m[raddr];
		rsize <= size_m[raddr];
		rprev <= prev_m[raddr];
	end

endmodule

// ----- rtl/bta_seq.sv -----
// Sequencer of the allocator: block walk, carve, merge and resize steps.
module bta_seq import bta_pkg::*; #(
	parameter int unsigned ARENA_BYTES = BTA_ARENA_BYTES,
	parameter int unsigned OW          = $clog2(ARENA_BYTES + 32768) + 1,
	parameter int unsigned IW          = $clog2(ARENA_BYTES / 4)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACT_W-1:0]  act,
	input  logic [ADDR_W-1:0] addr,
	input  logic [ADDR_W-1:0] req,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              out_free,
	output logic              idle,
	output logic              done,
	output bta_res_t          res,
	output bta_we_t           mem_we,
	output logic [IW-1:0]     mem_waddr,
	output logic              mem_wbusy,
	output logic [OW-1:0]     mem_wsize,
	output logic [OW-1:0]     mem_wprev,
	output logic [IW-1:0]     mem_raddr,
	input  logic              mem_rbusy,
	input  logic [OW-1:0]     mem_rsize,
	input  logic [OW-1:0]     mem_rprev,
	output logic [OW-1:0]     alu_a,
	output logic [OW-1:0]     alu_b,
	output logic              alu_hdr,
	output logic              alu_sub,
	input  logic [OW-1:0]     alu_y
);

	localparam logic [5:0] S_INIT = 6'd0,  S_IDLE = 6'd1,  S_PREP = 6'd2,  F_CHK  = 6'd3;
	localparam logic [5:0] F_NXT  = 6'd4,  F_HIT  = 6'd5,  R_N    = 6'd6,  R_NB   = 6'd7;
	localparam logic [5:0] R_P    = 6'd8,  R_PR   = 6'd9,  R_PB   = 6'd10, R_T0   = 6'd11;
	localparam logic [5:0] R_T1   = 6'd12, R_T2   = 6'd13, PL1    = 6'd14, PL2    = 6'd15;
	localparam logic [5:0] PL3    = 6'd16, PL4    = 6'd17, PL5    = 6'd18, A_CHK  = 6'd19;
	localparam logic [5:0] A_EV   = 6'd20, A_C1   = 6'd21, A_C2   = 6'd22, A_C3   = 6'd23;
	localparam logic [5:0] A_C4   = 6'd24, A_END  = 6'd25, FR_RD  = 6'd26, FR_H   = 6'd27;
	localparam logic [5:0] FR_N   = 6'd28, FR_NB  = 6'd29, FR_NB2 = 6'd30, FR_P   = 6'd31;
	localparam logic [5:0] FR_PR  = 6'd32, FR_PB  = 6'd33, FR_W   = 6'd34, FR_W2  = 6'd35;
	localparam logic [5:0] S_DONE = 6'd36;

	logic [5:0]        state_q;
	logic [OW-1:0]     arena_q, arena_cfg, arena_nx, cfg_ext;
	logic [OW-1:0]     s4_q, s4p12_q, addr_q, h_q, blk_q, hsz_q, hpv_q, nxt_q, nsz_q;
	logic [OW-1:0]     p_q, psz_q, ppv_q, tot_q, t_q, last_q, base_q, bpv_q, res_q, start_q;
	logic              nf_q, pf_q, rv_q, anew_q;
	logic [ACT_W-1:0]  act_q;
	logic [STAT_W-1:0] status_q;
	logic [OW-1:0]     rd_off, w_off;
	logic              split, carve, exact, moved;

	assign cfg_ext = OW'(cfg_data);
	always_comb begin
		arena_cfg = cfg_ext;
		if (cfg_ext < OW'(MIN_ARENA)) begin
			arena_cfg = OW'(MIN_ARENA);
		end
		if (cfg_ext > OW'(ARENA_BYTES)) begin
			arena_cfg = OW'(ARENA_BYTES);
		end
		arena_cfg[1:0] = 2'b00;
	end
	assign arena_nx = cfg_we ? arena_cfg : arena_q;

	assign split = tot_q >= s4p12_q;
	assign carve = !mem_rbusy && (mem_rsize >= s4p12_q);
	assign exact = !mem_rbusy && (mem_rsize == s4_q);

	assign mem_raddr = rd_off[IW+1:2];
	assign mem_waddr = w_off[IW+1:2];

	always_comb begin
		alu_a     = '0;
		alu_b     = '0;
		alu_hdr   = 1'b0;
		alu_sub   = 1'b0;
		rd_off    = '0;
		w_off     = '0;
		mem_we    = '0;
		mem_wbusy = 1'b0;
		mem_wsize = '0;
		mem_wprev = '0;
		case (state_q)
			S_INIT, S_IDLE: begin
				if (state_q == S_INIT || cfg_we) begin
					alu_a     = arena_nx;
					alu_hdr   = 1'b1;
					alu_sub   = 1'b1;
					mem_we    = '1;
					mem_wsize = alu_y;
				end else begin
					alu_a = OW'(req);
					alu_b = OW'(3);
				end
			end
			S_PREP: begin
				alu_a   = s4_q;
				alu_hdr = 1'b1;
			end
			F_CHK: begin
				rd_off  = h_q;
				alu_a   = h_q;
				alu_hdr = 1'b1;
			end
			F_NXT, F_HIT: begin
				alu_a   = h_q;
				alu_b   = mem_rsize;
				alu_hdr = 1'b1;
			end
			R_N, FR_N: begin
				rd_off = nxt_q;
			end
			R_P, FR_P: begin
				alu_a   = blk_q;
				alu_b   = hpv_q;
				alu_hdr = 1'b1;
				alu_sub = 1'b1;
			end
			R_PR, FR_PR: begin
				rd_off = p_q;
			end
			R_T0: begin
				alu_a   = hsz_q;
				alu_b   = pf_q ? psz_q : '0;
				alu_hdr = pf_q;
			end
			R_T1: begin
				alu_a   = tot_q;
				alu_b   = nf_q ? nsz_q : '0;
				alu_hdr = nf_q;
			end
			R_T2: begin
				alu_a   = p_q;
				alu_hdr = 1'b1;
			end
			PL1: begin
				alu_a   = base_q;
				alu_b   = tot_q;
				alu_hdr = 1'b1;
			end
			PL2: begin
				alu_a     = tot_q;
				alu_b     = s4_q;
				alu_hdr   = 1'b1;
				alu_sub   = 1'b1;
				w_off     = base_q;
				mem_we    = '1;
				mem_wbusy = 1'b1;
				mem_wsize = split ? s4_q : tot_q;
				mem_wprev = bpv_q;
			end
			PL3: begin
				alu_a   = base_q;
				alu_b   = s4_q;
				alu_hdr = 1'b1;
			end
			PL4: begin
				w_off     = t_q;
				mem_we    = '1;
				mem_wsize = last_q;
				mem_wprev = s4_q;
			end
			PL5: begin
				w_off       = nxt_q;
				mem_we.prev = nxt_q < arena_q;
				mem_wprev   = last_q;
			end
			A_CHK: begin
				rd_off = h_q;
			end
			A_EV: begin
				alu_a   = h_q;
				alu_b   = (exact && !carve) ? '0 : mem_rsize;
				alu_hdr = 1'b1;
				w_off   = h_q;
				if (exact && !carve) begin
					mem_we.busy = 1'b1;
					mem_wbusy   = 1'b1;
				end
			end
			A_C1: begin
				alu_a   = nxt_q;
				alu_b   = s4_q;
				alu_hdr = 1'b1;
				alu_sub = 1'b1;
			end
			A_C2: begin
				alu_a       = nsz_q;
				alu_b       = s4_q;
				alu_hdr     = 1'b1;
				alu_sub     = 1'b1;
				w_off       = nxt_q;
				mem_we.prev = nxt_q < arena_q;
				mem_wprev   = s4_q;
			end
			A_C3: begin
				alu_a       = t_q;
				alu_hdr     = 1'b1;
				w_off       = h_q;
				mem_we.size = 1'b1;
				mem_wsize   = tot_q;
			end
			A_C4: begin
				w_off     = t_q;
				mem_we    = '1;
				mem_wbusy = 1'b1;
				mem_wsize = s4_q;
				mem_wprev = tot_q;
			end
			FR_RD: begin
				rd_off = blk_q;
			end
			FR_H: begin
				alu_a       = blk_q;
				alu_b       = mem_rsize;
				alu_hdr     = 1'b1;
				w_off       = blk_q;
				mem_we.busy = 1'b1;
			end
			FR_NB, FR_PB: begin
				alu_a   = tot_q;
				alu_b   = mem_rsize;
				alu_hdr = 1'b1;
			end
			FR_NB2: begin
				alu_a   = nxt_q;
				alu_b   = nsz_q;
				alu_hdr = 1'b1;
			end
			FR_W: begin
				w_off       = start_q;
				mem_we.size = 1'b1;
				mem_wsize   = tot_q;
			end
			FR_W2: begin
				w_off       = nxt_q;
				mem_we.prev = nxt_q < arena_q;
				mem_wprev   = tot_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			arena_q  <= OW'(ARENA_BYTES);
			act_q    <= '0;
			status_q <= ST_OK;
			s4_q     <= '0;
			s4p12_q  <= '0;
			addr_q   <= '0;
			h_q      <= '0;
			blk_q    <= '0;
			hsz_q    <= '0;
			hpv_q    <= '0;
			nxt_q    <= '0;
			nsz_q    <= '0;
			p_q      <= '0;
			psz_q    <= '0;
			ppv_q    <= '0;
			tot_q    <= '0;
			t_q      <= '0;
			last_q   <= '0;
			base_q   <= '0;
			bpv_q    <= '0;
			res_q    <= '0;
			start_q  <= '0;
			nf_q     <= 1'b0;
			pf_q     <= 1'b0;
			rv_q     <= 1'b0;
			anew_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				arena_q <= arena_cfg;
			end
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						act_q   <= act;
						addr_q  <= OW'(addr);
						s4_q    <= {alu_y[OW-1:2], 2'b00};
						rv_q    <= 1'b0;
						anew_q  <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					s4p12_q <= alu_y;
					h_q     <= '0;
					res_q   <= '0;
					if (act_q == ACT_ALLOC || (act_q == ACT_REALLOC && addr_q == '0)) begin
						state_q <= A_CHK;
					end else if ((act_q == ACT_FREE || act_q == ACT_REALLOC) &&
					             addr_q != '0) begin
						state_q <= F_CHK;
					end else begin
						status_q <= ST_IGNORED;
						state_q  <= S_DONE;
					end
				end
				F_CHK: begin
					if (h_q >= arena_q) begin
						status_q <= ST_IGNORED;
						state_q  <= S_DONE;
					end else if (alu_y == addr_q) begin
						state_q <= F_HIT;
					end else begin
						state_q <= F_NXT;
					end
				end
				F_NXT: begin
					h_q     <= alu_y;
					state_q <= F_CHK;
				end
				F_HIT: begin
					blk_q <= h_q;
					hsz_q <= mem_rsize;
					hpv_q <= mem_rprev;
					nxt_q <= alu_y;
					if (!mem_rbusy) begin
						status_q <= ST_IGNORED;
						state_q  <= S_DONE;
					end else if (act_q == ACT_FREE) begin
						status_q <= ST_OK;
						state_q  <= FR_RD;
					end else begin
						status_q <= ST_OK;
						res_q    <= addr_q;
						rv_q     <= 1'b1;
						state_q  <= R_N;
					end
				end
				R_N: begin
					nf_q    <= 1'b0;
					state_q <= (nxt_q < arena_q) ? R_NB : R_P;
				end
				R_NB: begin
					nf_q    <= !mem_rbusy;
					nsz_q   <= mem_rsize;
					state_q <= R_P;
				end
				R_P: begin
					pf_q    <= 1'b0;
					p_q     <= alu_y;
					state_q <= (blk_q == '0) ? R_T0 : R_PR;
				end
				R_PR: state_q <= R_PB;
				R_PB: begin
					pf_q    <= !mem_rbusy;
					psz_q   <= mem_rsize;
					ppv_q   <= mem_rprev;
					state_q <= R_T0;
				end
				R_T0: begin
					tot_q   <= alu_y;
					state_q <= (s4_q == hsz_q) ? S_DONE : R_T1;
				end
				R_T1: begin
					tot_q   <= alu_y;
					state_q <= R_T2;
				end
				R_T2: begin
					if (tot_q >= s4_q) begin
						base_q <= pf_q ? p_q : blk_q;
						bpv_q  <= pf_q ? ppv_q : hpv_q;
						if (pf_q) begin
							res_q <= alu_y;
						end
						state_q <= PL1;
					end else begin
						anew_q  <= 1'b1;
						h_q     <= '0;
						state_q <= A_CHK;
					end
				end
				PL1: begin
					nxt_q   <= alu_y;
					state_q <= PL2;
				end
				PL2: begin
					last_q  <= split ? alu_y : tot_q;
					state_q <= split ? PL3 : PL5;
				end
				PL3: begin
					t_q     <= alu_y;
					state_q <= PL4;
				end
				PL4: state_q <= PL5;
				PL5: state_q <= S_DONE;
				A_CHK: begin
					if (h_q >= arena_q) begin
						res_q    <= '0;
						status_q <= ST_NOSPACE;
						state_q  <= S_DONE;
					end else begin
						state_q <= A_EV;
					end
				end
				A_EV: begin
					if (carve) begin
						nxt_q   <= alu_y;
						nsz_q   <= mem_rsize;
						state_q <= A_C1;
					end else if (exact) begin
						res_q   <= alu_y;
						state_q <= A_END;
					end else begin
						h_q     <= alu_y;
						state_q <= A_CHK;
					end
				end
				A_C1: begin
					t_q     <= alu_y;
					state_q <= A_C2;
				end
				A_C2: begin
					tot_q   <= alu_y;
					state_q <= A_C3;
				end
				A_C3: begin
					res_q   <= alu_y;
					state_q <= A_C4;
				end
				A_C4: state_q <= A_END;
				A_END: begin
					status_q <= ST_OK;
					state_q  <= anew_q ? FR_RD : S_DONE;
				end
				FR_RD: state_q <= FR_H;
				FR_H: begin
					hpv_q   <= mem_rprev;
					tot_q   <= mem_rsize;
					nxt_q   <= alu_y;
					start_q <= blk_q;
					state_q <= FR_N;
				end
				FR_N: state_q <= (nxt_q < arena_q) ? FR_NB : FR_P;
				FR_NB: begin
					nsz_q <= mem_rsize;
					if (!mem_rbusy) begin
						tot_q   <= alu_y;
						state_q <= FR_NB2;
					end else begin
						state_q <= FR_P;
					end
				end
				FR_NB2: begin
					nxt_q   <= alu_y;
					state_q <= FR_P;
				end
				FR_P: begin
					p_q     <= alu_y;
					state_q <= (blk_q == '0) ? FR_W : FR_PR;
				end
				FR_PR: state_q <= FR_PB;
				FR_PB: begin
					if (!mem_rbusy) begin
						tot_q   <= alu_y;
						start_q <= p_q;
					end
					state_q <= FR_W;
				end
				FR_W: state_q <= FR_W2;
				FR_W2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign moved = rv_q && (res_q != '0) && (res_q != addr_q);
	assign idle  = state_q == S_IDLE;
	assign done  = (state_q == S_DONE) && out_free;

	always_comb begin
		res.result_address = res_q[ADDR_W-1:0];
		res.status         = status_q;
		res.moved          = moved;
		res.old_address    = moved ? addr_q[ADDR_W-1:0] : '0;
	end

endmodule

// ----- rtl/boundary_tag_heap_allocator_unit.sv -----
// Top level of the first-fit boundary-tag heap allocator.
// Usage:
//  - Request channel s_*: s_tuser carries the action (allocate, free, reallocate),
//    s_tdata the payload address and requested size. One request at a time.
//  - Response channel m_*: one response per request, held in an output register
//    until taken; the sequencer waits in its final step while the register is full and m_tready is low.
//  - cfg_we/cfg_data set the arena size (clamped, rounded to 4 bytes) and, while the sequencer is
//    idle, rebuild the arena as one free block in the same cycle.
//  - Operation: the sequencer walks the block headers one by one while searching for an
//    address and again while searching for free space, then updates the headers.
//    Each header step costs one read of the header memory and one pass through the
//    shared adder.
//  - After reset the S_INIT state writes the initial free block; s_tready rises in the next cycle.
//  - s_tready is high only while the sequencer is idle.
module boundary_tag_heap_allocator_unit import bta_pkg::*; #(
	parameter int unsigned ARENA_BYTES = BTA_ARENA_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // address[13:0], req_size[27:14], zero
	input  logic [ACT_W-1:0]   s_tuser,  // action[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // result_address, status, moved, old_address, zero
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int unsigned OW    = $clog2(ARENA_BYTES + 32768) + 1;
	localparam int unsigned DEPTH = ARENA_BYTES / 4;
	localparam int unsigned IW    = $clog2(DEPTH);

	bta_res_t           res;
	bta_we_t            mem_we;
	logic [IW-1:0]      mem_waddr, mem_raddr;
	logic               mem_wbusy, mem_rbusy;
	logic [OW-1:0]      mem_wsize, mem_wprev, mem_rsize, mem_rprev;
	logic [OW-1:0]      alu_a, alu_b, alu_y;
	logic               alu_hdr, alu_sub;
	logic               idle, done, out_free;
	logic               m_valid_q;
	logic [TDATA_W-1:0] m_data_q;

	bta_alu #(.OW(OW)) u_alu (
		.a(alu_a), .b(alu_b), .hdr(alu_hdr), .sub(alu_sub), .y(alu_y)
	);

	bta_hdr_ram #(.DEPTH(DEPTH), .DW(OW)) u_ram (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wbusy(mem_wbusy),
		.wsize(mem_wsize), .wprev(mem_wprev), .raddr(mem_raddr),
		.rbusy(mem_rbusy), .rsize(mem_rsize), .rprev(mem_rprev)
	);

	bta_seq #(.ARENA_BYTES(ARENA_BYTES), .OW(OW), .IW(IW)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid && s_tready), .act(s_tuser),
		.addr(s_tdata[ADDR_W-1:0]), .req(s_tdata[2*ADDR_W-1:ADDR_W]),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .out_free(out_free),
		.idle(idle), .done(done), .res(res),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wbusy(mem_wbusy),
		.mem_wsize(mem_wsize), .mem_wprev(mem_wprev), .mem_raddr(mem_raddr),
		.mem_rbusy(mem_rbusy), .mem_rsize(mem_rsize), .mem_rprev(mem_rprev),
		.alu_a(alu_a), .alu_b(alu_b), .alu_hdr(alu_hdr), .alu_sub(alu_sub),
		.alu_y(alu_y)
	);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (done) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {1'b0, res.old_address, res.moved, res.status,
				              res.result_address};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15:14] == ST_OK)
		else $error("moved set on a failed response");

	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:14] == ST_IGNORED |-> m_tdata[13:0] == '0 && !m_tdata[16])
		else $error("ignored response carries an address");

endmodule
